// ===== rtl/hard_link_inode_dedup_table_unit_defines.svh =====
// ---------------------------------------------------------------------------
// hard link inode dedup table unit - assertion macros
// shared property forms for the dedup table checks
// ---------------------------------------------------------------------------
`ifndef HARD_LINK_INODE_DEDUP_TABLE_UNIT_DEFINES_SVH
`define HARD_LINK_INODE_DEDUP_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define HLIDT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hlidt same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define HLIDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hlidt next-cycle check failed");

`endif

// ===== rtl/hlidt_pkg.sv =====
// ---------------------------------------------------------------------------
// hlidt_pkg
// transaction types, outcome codes and hash constants of the dedup table
// ---------------------------------------------------------------------------
package hlidt_pkg;

   localparam int unsigned DEVICE_W  = 32;
   localparam int unsigned INODE_W   = 64;
   localparam int unsigned HANDLE_W  = 20;
   localparam int unsigned OUTCOME_W = 2;
   localparam int unsigned SLOT_IDX_W = 10;
   localparam int unsigned KEY_W     = 64;
   localparam int unsigned HALF_W    = 32;

   // 64-bit golden-ratio multiplier, split in halves
   localparam logic [HALF_W-1:0] GOLDEN_HI = 32'h9E37_79B9;
   localparam logic [HALF_W-1:0] GOLDEN_LO = 32'h7F4A_7C15;

   localparam logic [OUTCOME_W-1:0] OUTCOME_NEW   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FOUND = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FULL  = 2'd2;

   typedef struct packed {
      logic [DEVICE_W-1:0] device_id;
      logic [INODE_W-1:0]  inode_number;
      logic [HANDLE_W-1:0] entry_handle;
   } req_type;

   typedef struct packed {
      logic [OUTCOME_W-1:0]  outcome;
      logic [HANDLE_W-1:0]   stored_handle;
      logic [SLOT_IDX_W-1:0] slot_index;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [DEVICE_W-1:0] device;
      logic [INODE_W-1:0]  inode;
      logic [HANDLE_W-1:0] handle;
   } slot_entry_type;

   localparam int unsigned ENTRY_W = $bits(slot_entry_type);

endpackage

// ===== rtl/hlidt_ram.sv =====
// ---------------------------------------------------------------------------
// hlidt_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module hlidt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hard_link_inode_dedup_table_unit.sv =====
// ---------------------------------------------------------------------------
// hard_link_inode_dedup_table_unit
// flow: request, three passes of the shared 32x32 multiplier, hash, one table read per probe
//   (P probes, 1 or more), then the response register; req_stall is high outside idle, so a
//   new transaction is taken only after the previous response has been handed on
// reset: synchronous; afterwards a clearing pass over all 2**TABLE_LOG2 slots empties the table,
//   with req_stall high until it completes
// ---------------------------------------------------------------------------
`include "hard_link_inode_dedup_table_unit_defines.svh"

module hard_link_inode_dedup_table_unit
   import hlidt_pkg::*;
#(
   parameter int unsigned TABLE_LOG2 = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // table geometry
   localparam int unsigned CNT_W      = TABLE_LOG2 + 1;
   localparam int unsigned HALF_SLOTS = 2 ** (TABLE_LOG2 - 1);
   localparam int unsigned SLOT_LSB   = KEY_W - TABLE_LOG2;
   localparam int unsigned STEP_LSB   = KEY_W - 2 * TABLE_LOG2 - 1;
   localparam logic [TABLE_LOG2-1:0] LAST_SLOT = {TABLE_LOG2{1'b1}};
   localparam logic [CNT_W-1:0]      HALF     = CNT_W'(HALF_SLOTS);

   // sequencer codes
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MUL0  = 3'd2;
   localparam logic [2:0] ST_MUL1  = 3'd3;
   localparam logic [2:0] ST_MUL2  = 3'd4;
   localparam logic [2:0] ST_HASH  = 3'd5;
   localparam logic [2:0] ST_LOOK  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]            state_ff, state_in;
   req_type               req_ff, req_in;
   logic [KEY_W-1:0]      acc_ff, acc_in;
   logic [KEY_W-1:0]      mul_ff, mul_in;
   logic [TABLE_LOG2-1:0] slot_ff, slot_in;
   logic [TABLE_LOG2-1:0] step_ff, step_in;
   logic [TABLE_LOG2-1:0] probe_ff, probe_in;
   logic [TABLE_LOG2-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // key halves: device overlaps the upper inode bits
   logic [HALF_W-1:0]     key_hi, key_lo;
   logic [HALF_W-1:0]     mul_a, mul_b;
   logic [KEY_W-1:0]      prod;
   logic [TABLE_LOG2-1:0] slot_next;

   // table ram
   logic                  ram_wr_en;
   logic [TABLE_LOG2-1:0] ram_wr_addr;
   slot_entry_type        ram_wr_entry;
   logic                  ram_rd_en;
   logic [TABLE_LOG2-1:0] ram_rd_addr;
   logic [ENTRY_W-1:0]    ram_rd_data;
   slot_entry_type        entry;

   logic                  hit, table_full, do_insert;
   logic [SLOT_IDX_W+TABLE_LOG2-1:0] slot_wide;
   logic                  rsp_free;

   assign key_hi = req_ff.device_id | req_ff.inode_number[KEY_W-1:HALF_W];
   assign key_lo = req_ff.inode_number[HALF_W-1:0];

   // one shared 32x32 multiplier, three passes for the low 64 product bits
   always_comb begin
      mul_a = key_lo;
      mul_b = GOLDEN_LO;
      case (state_ff)
         ST_MUL1: begin
            mul_a = key_hi;
            mul_b = GOLDEN_LO;
         end
         ST_MUL2: begin
            mul_a = key_lo;
            mul_b = GOLDEN_HI;
         end
         default: begin
            mul_a = key_lo;
            mul_b = GOLDEN_LO;
         end
      endcase
   end

   assign mul_in = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

   // final product: last cross term lands in the upper half
   assign prod = {acc_ff[KEY_W-1:HALF_W] + mul_ff[HALF_W-1:0], acc_ff[HALF_W-1:0]};

   assign slot_next = slot_ff + step_ff;

   assign entry      = slot_entry_type'(ram_rd_data);
   assign hit        = entry.valid && (entry.device == req_ff.device_id)
                       && (entry.inode == req_ff.inode_number);
   assign table_full = (occ_ff >= HALF);
   assign do_insert  = (state_ff == ST_LOOK) && !entry.valid && !table_full;

   // slot number masked or zero-extended to the response width
   assign slot_wide = {{SLOT_IDX_W{1'b0}}, slot_ff};

   // output register can take a new response
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // ram port control: clearing pass, probe reads, insert write
   always_comb begin
      ram_wr_en    = 1'b0;
      ram_wr_addr  = slot_ff;
      ram_wr_entry = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = slot_next;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
      end else if (do_insert) begin
         ram_wr_en           = 1'b1;
         ram_wr_entry.valid  = 1'b1;
         ram_wr_entry.device = req_ff.device_id;
         ram_wr_entry.inode  = req_ff.inode_number;
         ram_wr_entry.handle = req_ff.entry_handle;
      end
      if (state_ff == ST_HASH) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = prod[SLOT_LSB +: TABLE_LOG2];
      end else if (state_ff == ST_LOOK) begin
         // speculative read of the next probe slot
         ram_rd_en = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      acc_in       = acc_ff;
      slot_in      = slot_ff;
      step_in      = step_ff;
      probe_in     = probe_ff;
      clr_in       = clr_ff;
      occ_in       = occ_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_MUL0;
            end
         end
         ST_MUL0: begin
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            acc_in   = mul_ff;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            acc_in[KEY_W-1:HALF_W] = acc_ff[KEY_W-1:HALF_W] + mul_ff[HALF_W-1:0];
            state_in = ST_HASH;
         end
         ST_HASH: begin
            // home slot from the top bits, odd step from the bits below
            slot_in  = prod[SLOT_LSB +: TABLE_LOG2];
            step_in  = prod[STEP_LSB +: TABLE_LOG2] | TABLE_LOG2'(1);
            probe_in = '0;
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (!entry.valid) begin
               if (table_full) begin
                  res_in = '{outcome: OUTCOME_FULL, stored_handle: '0, slot_index: '0};
               end else begin
                  res_in = '{outcome: OUTCOME_NEW, stored_handle: '0,
                             slot_index: slot_wide[SLOT_IDX_W-1:0]};
                  occ_in = occ_ff + 1'b1;
               end
               state_in = ST_DONE;
            end else if (hit) begin
               res_in = '{outcome: OUTCOME_FOUND, stored_handle: entry.handle,
                          slot_index: slot_wide[SLOT_IDX_W-1:0]};
               state_in = ST_DONE;
            end else if (probe_ff == LAST_SLOT) begin
               // one full pass without a free slot
               res_in   = '{outcome: OUTCOME_FULL, stored_handle: '0, slot_index: '0};
               state_in = ST_DONE;
            end else begin
               slot_in  = slot_next;
               probe_in = probe_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         occ_ff       <= '0;
         probe_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         occ_ff       <= occ_in;
         probe_ff     <= probe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      acc_ff  <= acc_in;
      mul_ff  <= mul_in;
      slot_ff <= slot_in;
      step_ff <= step_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   hlidt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (2 ** TABLE_LOG2)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // occupancy never passes half the slots
   `HLIDT_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_ff <= HALF)
   // every insert bumps the occupancy by exactly one
   `HLIDT_ASSERT_NEXT(a_occ_step, clock, reset, do_insert, occ_ff == $past(occ_ff) + 1'b1)
   // table writes only come from the clearing pass or an insert into an empty slot
   `HLIDT_ASSERT_NOW(a_wr_src, clock, reset, ram_wr_en,
      (state_ff == ST_CLEAR) || ((state_ff == ST_LOOK) && !entry.valid))
   // no response can appear while the table is still being cleared
   `HLIDT_ASSERT_NOW(a_clear_quiet, clock, reset, state_ff == ST_CLEAR, !rsp_valid_ff)

endmodule
